[rtl/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned PRIO_BITS_DEF = 16;

  localparam int unsigned PRIO_IO_W = 16;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COUNT_O_W = 5;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } command_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic rd_tail;
    logic shift;
    logic ins;
    logic pop_rd;
    logic finish;
  } spq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_deq;
    logic full;
    logic empty;
    logic k_zero;
    logic greater;
    logic out_busy;
  } spq_sts_t;

endpackage

[rtl/spq_regs.sv]
// Configuration register block: capacity register on the APB port.
module spq_regs import spq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_AW-1:0]          paddr,
  input  logic [APB_DW-1:0]          pwdata,
  output logic [APB_DW-1:0]          prdata,
  output logic                       pready,
  output logic [$clog2(DEPTH+1)-1:0] cap_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] cap_q;
  logic [CMP_W-1:0] cap_ext;
  logic             sel_cap;

  assign pready  = 1'b1;
  assign sel_cap = (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && sel_cap) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = sel_cap ? {{(APB_DW-CAP_W){1'b0}}, cap_q} : '0;

  // a zero capacity acts as one, anything above the built depth as the depth
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_q == '0) begin
      cap_o = CNT_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      cap_o = CNT_W'(DEPTH);
    end else begin
      cap_o = cap_ext[CNT_W-1:0];
    end
  end

endmodule

[rtl/spq_datapath.sv]
// Datapath: entry memory, head and count registers, insertion scan and result register.
module spq_datapath import spq_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  spq_cmd_t                   cmd_i,
  output spq_sts_t                   sts_o,
  input  logic [$clog2(DEPTH+1)-1:0] cap_i,
  input  logic                       command_i,
  input  logic [PRIO_IO_W-1:0]       item_prio_i,
  input  logic [CHAR_W-1:0]          item_char_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [PRIO_IO_W-1:0]       out_prio_o,
  output logic [CHAR_W-1:0]          out_char_o,
  output logic [COUNT_O_W-1:0]       count_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned ENT_W = PRIO_BITS + CHAR_W;

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_q;

  logic [IDX_W-1:0]     head_q;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     k_q;
  logic                 cmd_q;
  logic [PRIO_BITS-1:0] prio_q;
  logic [CHAR_W-1:0]    char_q;

  logic                 out_valid_q;
  logic [1:0]           status_q;
  logic [PRIO_IO_W-1:0] out_prio_q;
  logic [CHAR_W-1:0]    out_char_q;
  logic [COUNT_O_W-1:0] count_o_q;

  logic [PRIO_BITS+PRIO_IO_W-1:0] prio_in_ext;
  logic [PRIO_BITS+PRIO_IO_W-1:0] prio_out_ext;
  logic [CNT_W+COUNT_O_W-1:0]     count_ext;
  logic [CNT_W-1:0]               count_d;
  logic [IDX_W-1:0]               head_d;
  logic [IDX_W-1:0]               wr_addr;
  logic [IDX_W-1:0]               rd_addr;
  logic [IDX_W-1:0]               tail_addr;
  logic [SUM_W-1:0]               sum_k;
  logic [SUM_W-1:0]               sum_km1;
  logic [PRIO_BITS-1:0]           rd_prio;
  logic                           full;
  logic                           empty;
  logic                           enq_ok;
  logic                           deq_ok;

  assign prio_in_ext = {{PRIO_BITS{1'b0}}, item_prio_i};
  assign rd_prio     = rd_q[ENT_W-1:CHAR_W];

  // slot(off) = (head + off) mod DEPTH, both terms below DEPTH + 1
  always_comb begin
    sum_k   = SUM_W'(head_q) + SUM_W'(k_q);
    sum_km1 = sum_k - SUM_W'(1);
    if (sum_k >= SUM_W'(DEPTH)) begin
      sum_k = sum_k - SUM_W'(DEPTH);
    end
    if (sum_km1 >= SUM_W'(DEPTH)) begin
      sum_km1 = sum_km1 - SUM_W'(DEPTH);
    end
    wr_addr   = sum_k[IDX_W-1:0];
    tail_addr = sum_km1[IDX_W-1:0];
    rd_addr   = cmd_i.rd_tail ? tail_addr : head_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      mem[wr_addr] <= rd_q;
    end else if (cmd_i.ins) begin
      mem[wr_addr] <= {prio_q, char_q};
    end
    if (cmd_i.rd_tail || cmd_i.pop_rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign full   = (count_q >= cap_i);
  assign empty  = (count_q == '0);
  assign enq_ok = (cmd_q == CMD_ENQ) && !full;
  assign deq_ok = (cmd_q == CMD_DEQ) && !empty;

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    if (enq_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (deq_ok) begin
      count_d = count_q - CNT_W'(1);
      head_d  = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
    end
  end

  assign count_ext    = {{COUNT_O_W{1'b0}}, count_d};
  assign prio_out_ext = {{PRIO_IO_W{1'b0}}, rd_prio};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        head_q      <= head_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= command_i;
      prio_q <= prio_in_ext[PRIO_BITS-1:0];
      char_q <= item_char_i;
      k_q    <= count_q;
    end else if (cmd_i.shift) begin
      k_q <= k_q - CNT_W'(1);
    end
    if (cmd_i.finish) begin
      count_o_q <= count_ext[COUNT_O_W-1:0];
      if (cmd_q == CMD_ENQ) begin
        status_q   <= full ? ST_FULL : ST_DONE;
        out_prio_q <= '0;
        out_char_q <= '0;
      end else begin
        status_q   <= empty ? ST_EMPTY : ST_DONE;
        out_prio_q <= empty ? '0 : prio_out_ext[PRIO_IO_W-1:0];
        out_char_q <= empty ? '0 : rd_q[CHAR_W-1:0];
      end
    end
  end

  assign sts_o.is_deq   = (cmd_q == CMD_DEQ);
  assign sts_o.full     = full;
  assign sts_o.empty    = empty;
  assign sts_o.k_zero   = (k_q == '0);
  assign sts_o.greater  = (rd_prio > prio_q);
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_prio_o  = out_prio_q;
  assign out_char_o  = out_char_q;
  assign count_o     = count_o_q;

endmodule

[rtl/spq_ctrl.sv]
// Controller: sequences accept, tail scan with shift, insert or pop, and result hand-off.
module spq_ctrl import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  spq_sts_t sts_i,
  output spq_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOADED,
    S_READ,
    S_CMP,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    stall_d = stall_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !stall_q) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOADED;
          stall_d    = 1'b1;
        end
      end
      S_LOADED: begin
        if (sts_i.is_deq) begin
          cmd_o.pop_rd = !sts_i.empty;
          state_d      = S_FIN;
        end else if (sts_i.full) begin
          state_d = S_FIN;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (sts_i.k_zero) begin
          cmd_o.ins = 1'b1;
          state_d   = S_FIN;
        end else begin
          cmd_o.rd_tail = 1'b1;
          state_d       = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.greater) begin
          cmd_o.shift = 1'b1;
          state_d     = S_READ;
        end else begin
          cmd_o.ins = 1'b1;
          state_d   = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
          stall_d      = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
        stall_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;

endmodule

[rtl/sorted_priority_queue.sv]
// Top level of the sorted priority queue.
// The queue holds up to DEPTH (priority, character) entries in one memory kept in ascending
// priority order from a circular head slot; equal priorities leave in arrival order. One item
// is in work at a time. A dequeue or a refused request passes from the loaded state to the
// finish state, where the result register is loaded. An enqueue scans from the tail, moving
// each entry with a larger priority one slot up; each entry moved takes a read state and a
// compare state because the entry memory has a single read port and registered read data.
// The input is taken again in the cycle after the result is loaded; a result waits in an
// output register while stalled.
// The capacity register lies at byte address 0 (reset 16; 0 acts as 1, above DEPTH as DEPTH).
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [PRIO_IO_W-1:0] item_prio_i,
  input  logic [CHAR_W-1:0]    item_char_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [PRIO_IO_W-1:0] out_prio_o,
  output logic [CHAR_W-1:0]    out_char_o,
  output logic [COUNT_O_W-1:0] count_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] cap;
  spq_cmd_t         cmd;
  spq_sts_t         sts;

  spq_regs #(
    .DEPTH (DEPTH)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spq_datapath #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cap_i       (cap),
    .command_i   (command_i),
    .item_prio_i (item_prio_i),
    .item_char_i (item_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .out_prio_o  (out_prio_o),
    .out_char_o  (out_char_o),
    .count_o     (count_o)
  );

endmodule

[rtl/spq_checker.sv]
// Port-level checker for the sorted priority queue, bound to the top level.
module spq_checker import spq_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [1:0]           status_o,
  input logic [PRIO_IO_W-1:0] out_prio_o,
  input logic [CHAR_W-1:0]    out_char_o,
  input logic [COUNT_O_W-1:0] count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(count_o))
    else $error("stalled result dropped or changed");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while another is in work");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_DONE) |-> (out_prio_o == '0) && (out_char_o == '0))
    else $error("refused request carries an entry");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (count_o == '0))
    else $error("empty refusal with nonzero count");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .out_prio_o  (out_prio_o),
  .out_char_o  (out_char_o),
  .count_o     (count_o)
);
